FILE: rtl/dpb_pkg.sv
// Shared types and constants for the depth pixel back-projection block.
package dpb_pkg;

  localparam int DIV_STEPS = 48;

  typedef enum logic [2:0] {
    REG_DEPTH_SCALE  = 3'd0,
    REG_CENTER_X     = 3'd1,
    REG_CENTER_Y     = 3'd2,
    REG_FOCAL_X      = 3'd3,
    REG_FOCAL_Y      = 3'd4,
    REG_COLOUR_MODE  = 3'd5,
    REG_DROP_INVALID = 3'd6
  } reg_index_t;

  localparam logic [7:0] FIXED_BLUE  = 8'd0;
  localparam logic [7:0] FIXED_GREEN = 8'd255;
  localparam logic [7:0] FIXED_RED   = 8'd255;

  localparam logic [47:0] POS_LIMIT = 48'h7FFF_FFFF_FFFF;
  localparam logic [47:0] NEG_LIMIT = 48'h8000_0000_0000;

  typedef struct packed {
    logic [11:0] column;
    logic [11:0] row_index;
    logic [15:0] depth;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } pixel_t;

  typedef struct packed {
    logic signed [47:0] point_x;
    logic signed [47:0] point_y;
    logic [31:0]        point_z;
    logic               invalid;
    logic [7:0]         out_blue;
    logic [7:0]         out_green;
    logic [7:0]         out_red;
  } point_t;

  typedef struct packed {
    logic       invalid;
    logic       neg_x;
    logic       neg_y;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } meta_t;

endpackage

FILE: rtl/depth_pixel_backprojection_top.sv
// Top level of the depth pixel back-projection pipeline.
// Takes one depth pixel per clock and returns its pinhole back-projected point
// on out_valid; busy stays low, so a new request is taken every cycle, and
// each point is on out_data for exactly one cycle and cannot be held off. The
// pipeline is one input stage, one multiply stage, 48 one-bit restoring divide
// stages shared in lockstep by x, y and z, and one output stage. Zero depth
// pixels are dropped or flagged per drop_invalid.
module depth_pixel_backprojection_top #(
  parameter int COORD_BITS = 12,
  parameter int DEPTH_BITS = 16
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  output logic            busy,
  input  dpb_pkg::pixel_t in_data,
  output logic            out_valid,
  output dpb_pkg::point_t out_data,
  input  logic            cfg_we,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_wdata
);

  localparam int N = dpb_pkg::DIV_STEPS;
  localparam logic [11:0] CMASK = 12'((64'd1 << COORD_BITS) - 64'd1);
  localparam logic [15:0] DMASK = 16'((64'd1 << DEPTH_BITS) - 64'd1);

  logic [15:0] depth_scale_r, center_x_r, center_y_r, focal_x_r, focal_y_r;
  logic        colour_mode_r, drop_invalid_r;
  logic [31:0] div_x_r, div_y_r, div_z_r;

  logic        a_vld_r;
  logic [15:0] a_col_r, a_row_r, a_dep_r;
  dpb_pkg::meta_t a_meta_r;

  logic           vld_r  [N+1];
  dpb_pkg::meta_t meta_r [N+1];
  logic [47:0]    nq_r   [N+1][3];
  logic [31:0]    rem_r  [N+1][3];
  logic [47:0]    nq_nxt [N][3];
  logic [31:0]    rem_nxt[N][3];
  logic [31:0]    dv     [3];

  logic           out_valid_r;
  dpb_pkg::point_t out_data_r;
  dpb_pkg::point_t out_nxt;

  logic        acc;
  logic [15:0] dep_m, col16, row16, s_eff, fx_eff, fy_eff;

  assign busy = 1'b0;
  assign acc  = start && !busy;

  assign s_eff  = (depth_scale_r == 16'd0) ? 16'd1 : depth_scale_r;
  assign fx_eff = (focal_x_r == 16'd0) ? 16'd1 : focal_x_r;
  assign fy_eff = (focal_y_r == 16'd0) ? 16'd1 : focal_y_r;

  assign dep_m = in_data.depth & DMASK;
  assign col16 = {in_data.column & CMASK, 4'd0};
  assign row16 = {in_data.row_index & CMASK, 4'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_scale_r  <= 16'd1000;
      center_x_r     <= 16'd5120;
      center_y_r     <= 16'd3840;
      focal_x_r      <= 16'd8400;
      focal_y_r      <= 16'd8400;
      colour_mode_r  <= 1'b0;
      drop_invalid_r <= 1'b0;
    end else if (cfg_we) begin
      case (dpb_pkg::reg_index_t'(cfg_index))
        dpb_pkg::REG_DEPTH_SCALE:  depth_scale_r  <= cfg_wdata;
        dpb_pkg::REG_CENTER_X:     center_x_r     <= cfg_wdata;
        dpb_pkg::REG_CENTER_Y:     center_y_r     <= cfg_wdata;
        dpb_pkg::REG_FOCAL_X:      focal_x_r      <= cfg_wdata;
        dpb_pkg::REG_FOCAL_Y:      focal_y_r      <= cfg_wdata;
        dpb_pkg::REG_COLOUR_MODE:  colour_mode_r  <= cfg_wdata[0];
        dpb_pkg::REG_DROP_INVALID: drop_invalid_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // divisor products track the static configuration
  always_ff @(posedge clk) begin
    div_x_r <= fx_eff * s_eff;
    div_y_r <= fy_eff * s_eff;
    div_z_r <= {16'd0, s_eff};
  end

  assign dv[0] = div_x_r;
  assign dv[1] = div_y_r;
  assign dv[2] = div_z_r;

  // input stage: offsets from the principal point as magnitude and sign
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
    end else begin
      a_vld_r <= acc && !((dep_m == 16'd0) && drop_invalid_r);
    end
    a_dep_r          <= dep_m;
    a_col_r          <= (col16 < center_x_r) ? center_x_r - col16 : col16 - center_x_r;
    a_row_r          <= (row16 < center_y_r) ? center_y_r - row16 : row16 - center_y_r;
    a_meta_r.invalid <= (dep_m == 16'd0);
    a_meta_r.neg_x   <= (col16 < center_x_r);
    a_meta_r.neg_y   <= (row16 < center_y_r);
    a_meta_r.blue    <= colour_mode_r ? in_data.blue  : dpb_pkg::FIXED_BLUE;
    a_meta_r.green   <= colour_mode_r ? in_data.green : dpb_pkg::FIXED_GREEN;
    a_meta_r.red     <= colour_mode_r ? in_data.red   : dpb_pkg::FIXED_RED;
  end

  // one restoring divide step per stage: quotient bits shift in at the bottom
  always_comb begin
    logic [32:0] trial;
    for (int k = 0; k < N; k++) begin
      for (int l = 0; l < 3; l++) begin
        trial = {rem_r[k][l], nq_r[k][l][47]};
        if (trial >= {1'b0, dv[l]}) begin
          rem_nxt[k][l] = 32'(trial - {1'b0, dv[l]});
          nq_nxt[k][l]  = {nq_r[k][l][46:0], 1'b1};
        end else begin
          rem_nxt[k][l] = trial[31:0];
          nq_nxt[k][l]  = {nq_r[k][l][46:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= N; k++) vld_r[k] <= 1'b0;
    end else begin
      vld_r[0] <= a_vld_r;
      for (int k = 0; k < N; k++) vld_r[k+1] <= vld_r[k];
    end
    meta_r[0]     <= a_meta_r;
    nq_r[0][0]    <= {32'(a_col_r * a_dep_r), 16'd0};
    nq_r[0][1]    <= {32'(a_row_r * a_dep_r), 16'd0};
    nq_r[0][2]    <= {16'd0, a_dep_r, 16'd0};
    for (int l = 0; l < 3; l++) rem_r[0][l] <= 32'd0;
    for (int k = 0; k < N; k++) begin
      meta_r[k+1] <= meta_r[k];
      for (int l = 0; l < 3; l++) begin
        nq_r[k+1][l]  <= nq_nxt[k][l];
        rem_r[k+1][l] <= rem_nxt[k][l];
      end
    end
  end

  // saturate, apply sign, zero invalid points
  always_comb begin
    logic [47:0] qx, qy;
    qx = nq_r[N][0];
    qy = nq_r[N][1];
    if (meta_r[N].neg_x) begin
      qx = 48'd0 - ((qx > dpb_pkg::NEG_LIMIT) ? dpb_pkg::NEG_LIMIT : qx);
    end else begin
      qx = (qx > dpb_pkg::POS_LIMIT) ? dpb_pkg::POS_LIMIT : qx;
    end
    if (meta_r[N].neg_y) begin
      qy = 48'd0 - ((qy > dpb_pkg::NEG_LIMIT) ? dpb_pkg::NEG_LIMIT : qy);
    end else begin
      qy = (qy > dpb_pkg::POS_LIMIT) ? dpb_pkg::POS_LIMIT : qy;
    end
    out_nxt.point_x   = meta_r[N].invalid ? 48'sd0 : $signed(qx);
    out_nxt.point_y   = meta_r[N].invalid ? 48'sd0 : $signed(qy);
    out_nxt.point_z   = meta_r[N].invalid ? 32'd0 : nq_r[N][2][31:0];
    out_nxt.invalid   = meta_r[N].invalid;
    out_nxt.out_blue  = meta_r[N].blue;
    out_nxt.out_green = meta_r[N].green;
    out_nxt.out_red   = meta_r[N].red;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[N];
    end
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_inv_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid |->
      out_data.point_x == 48'sd0 && out_data.point_y == 48'sd0 &&
      out_data.point_z == 32'd0)
    else $error("invalid point not zero");

  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid |-> !drop_invalid_r)
    else $error("invalid point not dropped");

  a_z_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.invalid |-> out_data.point_z != 32'd0)
    else $error("valid point with zero z");

  a_stage_vld: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[N] |=> out_valid)
    else $error("result lost at output stage");

endmodule

FILE: bench/testbench.sv
// Self-checking testbench for the depth pixel back-projection block.
`timescale 1ns / 100ps

module testbench;

  localparam logic [2:0] REG_UNUSED = 3'd7;
  localparam int DRAIN_CYCLES = 60;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_ITEMS = 66;

  typedef struct {
    bit              is_cfg;
    logic [2:0]      idx;
    logic [15:0]     val;
    dpb_pkg::pixel_t px;
    bit              has_exp;
    dpb_pkg::point_t exp_pt;
  } dir_row_t;

  logic            clk;
  logic            rst_n;
  logic            start;
  logic            busy;
  dpb_pkg::pixel_t in_data;
  logic            out_valid;
  dpb_pkg::point_t out_data;
  logic            cfg_we;
  logic [2:0]      cfg_index;
  logic [15:0]     cfg_wdata;

  logic [15:0] cam_scale, cam_cx, cam_cy, cam_fx, cam_fy;
  logic        cam_colour, cam_drop;

  dpb_pkg::point_t point_q[$];
  int              mismatches;
  int              results_seen;
  int              requests_sent;
  int              idle_pct;
  int              stall_cycles;
  dir_row_t        dir_rows[$];

  depth_pixel_backprojection_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [47:0] axis_coord(logic [11:0] pos, logic [15:0] centre,
                                             logic [15:0] focal, logic [15:0] dep,
                                             logic [15:0] scale);
    logic [63:0] p16, diff, num, q, f, s;
    logic        neg;
    p16  = 64'(pos) << 4;
    neg  = p16 < 64'(centre);
    diff = neg ? (64'(centre) - p16) : (p16 - 64'(centre));
    f    = (focal == 16'd0) ? 64'd1 : 64'(focal);
    s    = (scale == 16'd0) ? 64'd1 : 64'(scale);
    num  = (diff * 64'(dep)) << 16;
    q    = num / (f * s);
    if (neg) begin
      if (q > 64'(dpb_pkg::NEG_LIMIT)) q = 64'(dpb_pkg::NEG_LIMIT);
      q = 64'd0 - q;
      return q[47:0];
    end
    if (q > 64'(dpb_pkg::POS_LIMIT)) q = 64'(dpb_pkg::POS_LIMIT);
    return q[47:0];
  endfunction

  function automatic bit project_pixel(dpb_pkg::pixel_t p, output dpb_pkg::point_t r);
    logic [63:0] zq;
    r = '0;
    if (p.depth == 16'd0) begin
      if (cam_drop) return 1'b0;
      r.invalid = 1'b1;
    end else begin
      r.point_x = axis_coord(p.column, cam_cx, cam_fx, p.depth, cam_scale);
      r.point_y = axis_coord(p.row_index, cam_cy, cam_fy, p.depth, cam_scale);
      zq = (64'(p.depth) << 16) / ((cam_scale == 16'd0) ? 64'd1 : 64'(cam_scale));
      r.point_z = zq[31:0];
    end
    if (cam_colour) begin
      r.out_blue  = p.blue;
      r.out_green = p.green;
      r.out_red   = p.red;
    end else begin
      r.out_blue  = dpb_pkg::FIXED_BLUE;
      r.out_green = dpb_pkg::FIXED_GREEN;
      r.out_red   = dpb_pkg::FIXED_RED;
    end
    return 1'b1;
  endfunction

  function automatic void add_row(dir_row_t d);
    dir_rows.insert(dir_rows.size(), d);
  endfunction

  // hold off until the pipeline has drained, then write
  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    wait (point_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      dpb_pkg::REG_DEPTH_SCALE:  cam_scale  = val;
      dpb_pkg::REG_CENTER_X:     cam_cx     = val;
      dpb_pkg::REG_CENTER_Y:     cam_cy     = val;
      dpb_pkg::REG_FOCAL_X:      cam_fx     = val;
      dpb_pkg::REG_FOCAL_Y:      cam_fy     = val;
      dpb_pkg::REG_COLOUR_MODE:  cam_colour = val[0];
      dpb_pkg::REG_DROP_INVALID: cam_drop   = val[0];
      default: ;
    endcase
  endtask

  task automatic send_pixel(dpb_pkg::pixel_t p, bit has_exp, dpb_pkg::point_t exp_pt);
    dpb_pkg::point_t pred;
    bit              any;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    requests_sent++;
    any = project_pixel(p, pred);
    if (has_exp) point_q.insert(point_q.size(), exp_pt);
    else if (any) point_q.insert(point_q.size(), pred);
  endtask

  function automatic dpb_pkg::pixel_t random_pixel();
    dpb_pkg::pixel_t p;
    int              r;
    p = dpb_pkg::pixel_t'({$urandom, $urandom});
    r = $urandom_range(99);
    if (r < 12) p.depth = 16'd0;
    else if (r < 20) p.depth = 16'hFFFF;
    else if (r < 26) p.depth = 16'($urandom_range(1, 15));
    r = $urandom_range(99);
    if (r < 5) p.column = 12'd0;
    else if (r < 10) p.column = 12'hFFF;
    r = $urandom_range(99);
    if (r < 5) p.row_index = 12'd0;
    else if (r < 10) p.row_index = 12'hFFF;
    return p;
  endfunction

  function automatic dir_row_t cfg_row(logic [2:0] idx, logic [15:0] val);
    dir_row_t d;
    d = '{default: '0};
    d.is_cfg = 1'b1;
    d.idx    = idx;
    d.val    = val;
    return d;
  endfunction

  function automatic dir_row_t px_row(logic [11:0] col, logic [11:0] row, logic [15:0] dep,
                                      logic [23:0] bgr, bit has_exp, dpb_pkg::point_t e);
    dir_row_t d;
    d = '{default: '0};
    d.px      = '{col, row, dep, bgr[23:16], bgr[15:8], bgr[7:0]};
    d.has_exp = has_exp;
    d.exp_pt  = e;
    return d;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (point_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected point %p", out_data);
      end else begin
        dpb_pkg::point_t e;
        e = point_q.pop_front();
        if (out_data.point_x !== e.point_x || out_data.point_y !== e.point_y ||
            out_data.point_z !== e.point_z || out_data.invalid !== e.invalid ||
            out_data.out_blue !== e.out_blue || out_data.out_green !== e.out_green ||
            out_data.out_red !== e.out_red) begin
          mismatches++;
          if (mismatches <= 10) $display("point mismatch: expected %p got %p", e, out_data);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || cfg_we) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog expired");
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [15:0] phase_cfg[RANDOM_PHASES][7];
    start         = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    rst_n         = 1'b0;
    mismatches    = 0;
    results_seen  = 0;
    requests_sent = 0;
    stall_cycles  = 0;
    idle_pct      = 18;
    cam_scale  = 16'd1000;
    cam_cx     = 16'd5120;
    cam_cy     = 16'd3840;
    cam_fx     = 16'd8400;
    cam_fy     = 16'd8400;
    cam_colour = 1'b0;
    cam_drop   = 1'b0;

    add_row(px_row(12'd320, 12'd240, 16'd1000, 24'h123456, 1,
                   '{48'sd0, 48'sd0, 32'h10000, 1'b0, 8'd0, 8'd255, 8'd255}));
    add_row(px_row(12'd17, 12'd99, 16'd0, 24'hABCDEF, 1,
                   '{48'sd0, 48'sd0, 32'd0, 1'b1, 8'd0, 8'd255, 8'd255}));
    add_row(px_row(12'd0, 12'd0, 16'hFFFF, 24'hFFFFFF, 0, '0));
    add_row(px_row(12'hFFF, 12'hFFF, 16'hFFFF, 24'h000000, 0, '0));
    add_row(px_row(12'hFFF, 12'd0, 16'd1, 24'hAA55AA, 0, '0));
    add_row(cfg_row(REG_UNUSED, 16'd1234));
    add_row(px_row(12'd320, 12'd240, 16'd1000, 24'h55AA55, 0, '0));
    add_row(cfg_row(dpb_pkg::REG_COLOUR_MODE, 16'hFFFF));
    add_row(cfg_row(dpb_pkg::REG_DROP_INVALID, 16'd1));
    add_row(cfg_row(dpb_pkg::REG_DEPTH_SCALE, 16'd0));
    add_row(cfg_row(dpb_pkg::REG_CENTER_X, 16'd0));
    add_row(cfg_row(dpb_pkg::REG_CENTER_Y, 16'd0));
    add_row(cfg_row(dpb_pkg::REG_FOCAL_X, 16'd0));
    add_row(cfg_row(dpb_pkg::REG_FOCAL_Y, 16'd1));
    add_row(px_row(12'hFFF, 12'hFFF, 16'hFFFF, 24'h0C2238, 1,
                   '{dpb_pkg::POS_LIMIT, dpb_pkg::POS_LIMIT, 32'hFFFF0000, 1'b0,
                     8'h0C, 8'h22, 8'h38}));
    add_row(px_row(12'd5, 12'd6, 16'd0, 24'h010203, 0, '0));
    add_row(cfg_row(dpb_pkg::REG_CENTER_X, 16'hFFFF));
    add_row(cfg_row(dpb_pkg::REG_CENTER_Y, 16'hFFFF));
    add_row(px_row(12'd0, 12'd0, 16'hFFFF, 24'hFEDCBA, 1,
                   '{dpb_pkg::NEG_LIMIT, dpb_pkg::NEG_LIMIT, 32'hFFFF0000, 1'b0,
                     8'hFE, 8'hDC, 8'hBA}));
    add_row(cfg_row(dpb_pkg::REG_DEPTH_SCALE, 16'hFFFF));
    add_row(cfg_row(dpb_pkg::REG_FOCAL_X, 16'hFFFF));
    add_row(cfg_row(dpb_pkg::REG_FOCAL_Y, 16'hFFFF));
    add_row(cfg_row(dpb_pkg::REG_COLOUR_MODE, 16'hFFFE));
    add_row(cfg_row(dpb_pkg::REG_DROP_INVALID, 16'd2));
    add_row(px_row(12'd2048, 12'd1, 16'hFFFF, 24'h777777, 0, '0));
    add_row(px_row(12'd3, 12'd3000, 16'd0, 24'h777777, 0, '0));

    phase_cfg[0] = '{16'd1000, 16'd5120, 16'd3840, 16'd8400, 16'd8400, 16'd1, 16'd0};
    phase_cfg[1] = '{16'd1, 16'd0, 16'd0, 16'd1, 16'd1, 16'd1, 16'd1};
    phase_cfg[2] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0};
    phase_cfg[3] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'd1, 16'd1};
    phase_cfg[4] = '{16'd5000, 16'd32768, 16'd32768, 16'd16, 16'd16, 16'd1, 16'd0};
    phase_cfg[5] = '{16'd0, 16'd40000, 16'd20000, 16'd0, 16'd300, 16'd0, 16'd1};
    phase_cfg[6] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom)};
    phase_cfg[7] = '{16'd1000, 16'd5120, 16'd3840, 16'd8400, 16'd8400, 16'd1, 16'd0};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        start <= 1'b0;
        write_reg(dir_rows[i].idx, dir_rows[i].val);
      end else begin
        send_pixel(dir_rows[i].px, dir_rows[i].has_exp, dir_rows[i].exp_pt);
      end
    end

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      idle_pct = (ph < 3) ? 18 : (ph < 6) ? 56 : 0;
      start <= 1'b0;
      for (int r = 0; r < 7; r++) write_reg(3'(r), phase_cfg[ph][r]);
      for (int n = 0; n < PHASE_ITEMS; n++) send_pixel(random_pixel(), 1'b0, '0);
    end
    start <= 1'b0;

    wait (point_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d pixel requests over %0d camera settings, checked %0d points.",
             requests_sent, RANDOM_PHASES + 1, results_seen);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatching points", mismatches);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/dpb_pkg.sv
rtl/depth_pixel_backprojection_top.sv
bench/testbench.sv
